// File: src/mmd_pkg.sv
// ----------------------------------------------------------------------------
// mmd_pkg
// Shared widths, register map, state encoding and control structs for the
// multiscale min/max decimator.
// ----------------------------------------------------------------------------
package mmd_pkg;

	localparam int SAMPLE_W = 16;
	localparam int CHAN_W   = 6;
	localparam int LEVEL_W  = 4;
	localparam int NCH_W    = 7;
	localparam int NLV_W    = 4;
	localparam int COUNT_W  = 2;
	localparam int WORD_W   = COUNT_W + 2 * SAMPLE_W;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam int DEF_MAX_CHANNELS = 64;
	localparam int DEF_MAX_LEVELS   = 12;

	// register index, taken from paddr[2]
	localparam logic REG_NUM_CHANNELS = 1'b0;
	localparam logic REG_NUM_LEVELS   = 1'b1;

	localparam logic [NCH_W-1:0] NUM_CHANNELS_RST = NCH_W'(1);
	localparam logic [NLV_W-1:0] NUM_LEVELS_RST   = NLV_W'(12);

	// group fill codes
	localparam logic [COUNT_W-1:0] CNT_EMPTY = 2'd0;
	localparam logic [COUNT_W-1:0] CNT_ONE   = 2'd1;
	localparam logic [COUNT_W-1:0] CNT_TWO   = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_FLUSH
	} mmd_state_t;

	typedef struct packed {
		logic load;
		logic rd_en;
		logic wr_en;
		logic adv;
		logic push;
		logic push_last;
		logic pend_clr;
		logic clr_wr;
	} mmd_cmd_t;

	typedef struct packed {
		logic in_use;
		logic complete;
		logic final_lv;
		logic pend_valid;
		logic out_free;
		logic clr_done;
	} mmd_status_t;

endpackage

// File: src/mmd_if.sv
// ----------------------------------------------------------------------------
// mmd_if
// Valid/ready stream interfaces for samples in and min/max results out.
// ----------------------------------------------------------------------------
interface mmd_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [mmd_pkg::CHAN_W-1:0]           channel;
	logic signed [mmd_pkg::SAMPLE_W-1:0]  sample;

	modport source (output valid, output channel, output sample, input ready);
	modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface mmd_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [mmd_pkg::LEVEL_W-1:0]          level;
	logic [mmd_pkg::CHAN_W-1:0]           out_channel;
	logic signed [mmd_pkg::SAMPLE_W-1:0]  min_value;
	logic signed [mmd_pkg::SAMPLE_W-1:0]  max_value;
	logic                                 last;

	modport source (output valid, output level, output out_channel, output min_value,
		output max_value, output last, input ready);
	modport sink   (input valid, input level, input out_channel, input min_value,
		input max_value, input last, output ready);
endinterface

// File: src/multiscale_min_max_decimator_top.sv
// ----------------------------------------------------------------------------
// multiscale_min_max_decimator_top
// Per-channel decimate-by-3 min/max pyramid over interleaved samples.
// ----------------------------------------------------------------------------
// Usage:
//   samples: valid/ready stream of (channel, sample). Samples on channels at
//   or above num_channels are taken and dropped.
//   results: valid/ready stream of (level, out_channel, min_value, max_value,
//   last); one transfer per group completed by a sample, lowest level first,
//   last set on the final one of that sample.
//   APB: register 0 num_channels at 0x0, register 1 num_levels at 0x4.
// Timing: a sample is taken in the idle state, then each level it touches
//   costs a store read and an update through the single-ported group store,
//   plus a flush step to hand over the final result, if any. The first result
//   passes the pending register and then the output register.
// Reset: the group store is cleared, one entry per cycle, across all
//   MAX_CHANNELS*MAX_LEVELS entries; samples are held off meanwhile.
// Stall: a result waiting in the output register holds the walk only when
//   another result has to move out; otherwise the walk continues.
// ----------------------------------------------------------------------------
module multiscale_min_max_decimator_top #(
	parameter int MAX_CHANNELS = mmd_pkg::DEF_MAX_CHANNELS,
	parameter int MAX_LEVELS   = mmd_pkg::DEF_MAX_LEVELS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mmd_pkg::APB_AW-1:0]  paddr,
	input  logic [mmd_pkg::APB_DW-1:0]  pwdata,
	output logic [mmd_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	mmd_in_if.sink                      samples,
	mmd_out_if.source                   results
);
	import mmd_pkg::*;

	logic [NCH_W-1:0] num_channels;
	logic [NLV_W-1:0] num_levels;
	mmd_cmd_t         cmd;
	mmd_status_t      status;

	mmd_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.num_channels (num_channels),
		.num_levels   (num_levels)
	);

	mmd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.status   (status),
		.cmd      (cmd)
	);

	mmd_dp #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.MAX_LEVELS   (MAX_LEVELS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.num_channels (num_channels),
		.num_levels   (num_levels),
		.in_channel   (samples.channel),
		.in_sample    (samples.sample),
		.out_valid    (results.valid),
		.out_ready    (results.ready),
		.out_level    (results.level),
		.out_channel  (results.out_channel),
		.out_min      (results.min_value),
		.out_max      (results.max_value),
		.out_last     (results.last)
	);

endmodule

// File: src/mmd_regs.sv
// ----------------------------------------------------------------------------
// mmd_regs
// APB configuration registers: channel count and level count.
// ----------------------------------------------------------------------------
module mmd_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mmd_pkg::APB_AW-1:0]  paddr,
	input  logic [mmd_pkg::APB_DW-1:0]  pwdata,
	output logic [mmd_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output logic [mmd_pkg::NCH_W-1:0]   num_channels,
	output logic [mmd_pkg::NLV_W-1:0]   num_levels
);
	import mmd_pkg::*;

	logic [NCH_W-1:0] num_channels_q;
	logic [NLV_W-1:0] num_levels_q;
	logic             wr;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_channels_q <= NUM_CHANNELS_RST;
			num_levels_q   <= NUM_LEVELS_RST;
		end else if (wr) begin
			case (paddr[2])
				REG_NUM_CHANNELS: num_channels_q <= pwdata[NCH_W-1:0];
				REG_NUM_LEVELS:   num_levels_q   <= pwdata[NLV_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_NUM_CHANNELS: prdata = APB_DW'(num_channels_q);
			REG_NUM_LEVELS:   prdata = APB_DW'(num_levels_q);
			default:          prdata = '0;
		endcase
	end

	assign num_channels = num_channels_q;
	assign num_levels   = num_levels_q;

endmodule

// File: src/mmd_ctrl.sv
// ----------------------------------------------------------------------------
// mmd_ctrl
// Sequencer: clears the group store after reset, then walks one sample up
// the levels, one read and one update per level.
// ----------------------------------------------------------------------------
module mmd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  mmd_pkg::mmd_status_t  status,
	output mmd_pkg::mmd_cmd_t     cmd
);
	import mmd_pkg::*;

	mmd_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid && status.in_use) state_d = ST_READ;
			end
			ST_READ: state_d = ST_UPDATE;
			ST_UPDATE: begin
				if (!status.complete) begin
					state_d = status.pend_valid ? ST_FLUSH : ST_IDLE;
				end else if (!status.pend_valid || status.out_free) begin
					state_d = status.final_lv ? ST_FLUSH : ST_READ;
				end
			end
			ST_FLUSH: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clr_wr = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_READ: cmd.rd_en = 1'b1;
			ST_UPDATE: begin
				if (!status.complete) begin
					cmd.wr_en = 1'b1;
				end else if (!status.pend_valid || status.out_free) begin
					// older result goes out as not-last, new one waits in pend
					cmd.wr_en = 1'b1;
					cmd.adv   = 1'b1;
					cmd.push  = status.pend_valid;
				end
			end
			ST_FLUSH: begin
				if (status.out_free) begin
					cmd.push      = 1'b1;
					cmd.push_last = 1'b1;
					cmd.pend_clr  = 1'b1;
				end
			end
			default: ;
		endcase
	end

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !status.pend_valid)
		else $error("pending result left behind at idle");

	a_read_then_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (state_q == ST_UPDATE))
		else $error("read not followed by update");

	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && status.clr_done) |=> (state_q == ST_IDLE))
		else $error("clear pass did not end in idle");

endmodule

// File: src/mmd_dp.sv
// ----------------------------------------------------------------------------
// mmd_dp
// Datapath: group store (count, running min, running max per channel and
// level), min/max update, pending result and output register.
// ----------------------------------------------------------------------------
module mmd_dp #(
	parameter int MAX_CHANNELS = mmd_pkg::DEF_MAX_CHANNELS,
	parameter int MAX_LEVELS   = mmd_pkg::DEF_MAX_LEVELS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mmd_pkg::mmd_cmd_t                   cmd,
	output mmd_pkg::mmd_status_t                status,
	input  logic [mmd_pkg::NCH_W-1:0]           num_channels,
	input  logic [mmd_pkg::NLV_W-1:0]           num_levels,
	input  logic [mmd_pkg::CHAN_W-1:0]          in_channel,
	input  logic signed [mmd_pkg::SAMPLE_W-1:0] in_sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mmd_pkg::LEVEL_W-1:0]         out_level,
	output logic [mmd_pkg::CHAN_W-1:0]          out_channel,
	output logic signed [mmd_pkg::SAMPLE_W-1:0] out_min,
	output logic signed [mmd_pkg::SAMPLE_W-1:0] out_max,
	output logic                                out_last
);
	import mmd_pkg::*;

	localparam int DEPTH  = MAX_CHANNELS * MAX_LEVELS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LVC_W  = $clog2(MAX_LEVELS + 1);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_data_q;
	logic [WORD_W-1:0] wr_data;

	logic [ADDR_W-1:0]          addr_q, clr_addr_q, wr_addr;
	logic [CHAN_W-1:0]          ch_q;
	logic [LVC_W-1:0]           lv_q, levels_q, eff_levels;
	logic signed [SAMPLE_W-1:0] cur_min_q, cur_max_q;

	logic                       pend_valid_q;
	logic [LEVEL_W-1:0]         pend_level_q;
	logic signed [SAMPLE_W-1:0] pend_min_q, pend_max_q;

	logic                       out_valid_q, out_last_q;
	logic [LEVEL_W-1:0]         out_level_q;
	logic [CHAN_W-1:0]          out_channel_q;
	logic signed [SAMPLE_W-1:0] out_min_q, out_max_q;

	logic [COUNT_W-1:0]         rd_cnt;
	logic signed [SAMPLE_W-1:0] rd_min, rd_max, new_min, new_max;
	logic [COUNT_W-1:0]         new_cnt;
	logic                       complete;

	assign eff_levels = (int'(num_levels) > MAX_LEVELS) ? LVC_W'(MAX_LEVELS)
		: LVC_W'(num_levels);

	// store read/write, read data registered
	assign wr_addr = cmd.clr_wr ? clr_addr_q : addr_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en || cmd.clr_wr) mem[wr_addr] <= wr_data;
		if (cmd.rd_en) rd_data_q <= mem[addr_q];
	end

	assign rd_cnt = rd_data_q[WORD_W-1 -: COUNT_W];
	assign rd_min = rd_data_q[2*SAMPLE_W-1 -: SAMPLE_W];
	assign rd_max = rd_data_q[SAMPLE_W-1:0];

	always_comb begin
		complete = 1'b0;
		new_min  = (cur_min_q < rd_min) ? cur_min_q : rd_min;
		new_max  = (cur_max_q > rd_max) ? cur_max_q : rd_max;
		case (rd_cnt)
			CNT_EMPTY: begin
				new_cnt = CNT_ONE;
				new_min = cur_min_q;
				new_max = cur_max_q;
			end
			CNT_ONE: new_cnt = CNT_TWO;
			default: begin
				new_cnt  = CNT_EMPTY;
				complete = 1'b1;
			end
		endcase
	end

	assign wr_data = cmd.clr_wr ? {CNT_EMPTY, {(2*SAMPLE_W){1'b0}}}
		: {new_cnt, new_min, new_max};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// walk state for the sample in flight
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q      <= in_channel;
			cur_min_q <= in_sample;
			cur_max_q <= in_sample;
			lv_q      <= '0;
			levels_q  <= eff_levels;
			addr_q    <= ADDR_W'(int'(in_channel) * MAX_LEVELS);
		end else if (cmd.adv) begin
			cur_min_q <= new_min;
			cur_max_q <= new_max;
			lv_q      <= lv_q + 1'b1;
			addr_q    <= addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.adv) begin
			pend_valid_q <= 1'b1;
		end else if (cmd.pend_clr) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.adv) begin
			pend_level_q <= LEVEL_W'(lv_q + 1'b1);
			pend_min_q   <= new_min;
			pend_max_q   <= new_max;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_level_q   <= pend_level_q;
			out_channel_q <= ch_q;
			out_min_q     <= pend_min_q;
			out_max_q     <= pend_max_q;
			out_last_q    <= cmd.push_last;
		end
	end

	assign status.in_use     = ({1'b0, in_channel} < num_channels)
		&& (int'(in_channel) < MAX_CHANNELS) && (num_levels != '0);
	assign status.complete   = complete;
	assign status.final_lv   = ((lv_q + 1'b1) == levels_q);
	assign status.pend_valid = pend_valid_q;
	assign status.out_free   = !out_valid_q || out_ready;
	assign status.clr_done   = (int'(clr_addr_q) == DEPTH - 1);

	assign out_valid   = out_valid_q;
	assign out_level   = out_level_q;
	assign out_channel = out_channel_q;
	assign out_min     = out_min_q;
	assign out_max     = out_max_q;
	assign out_last    = out_last_q;

	a_push_has_pend: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> pend_valid_q)
		else $error("result pushed with no pending result");

	a_push_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> out_valid_q)
		else $error("output register not loaded after push");

	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> !(cmd.wr_en || cmd.rd_en || cmd.load))
		else $error("store access during clear pass");

endmodule

// File: sim/multiscale_min_max_decimator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiscale_min_max_decimator_top_tb
// Self-checking bench for the min/max decimation pyramid. A directed table
// covers the extremes, unused channels and the level register corners, then
// random segments at varied settings run against a decimation predictor.
// Both streams idle at random, and the rates change from phase to phase.
// ----------------------------------------------------------------------------
module multiscale_min_max_decimator_top_tb;
	import mmd_pkg::*;

	localparam int MAX_CH        = DEF_MAX_CHANNELS;
	localparam int MAX_LV        = DEF_MAX_LEVELS;
	localparam int SETTLE_CYCLES = 2 * DEF_MAX_LEVELS + 16;
	localparam int RAND_ITEMS    = 260;

	typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct {
		logic [LEVEL_W-1:0]         level;
		logic [CHAN_W-1:0]          chan;
		logic signed [SAMPLE_W-1:0] lo;
		logic signed [SAMPLE_W-1:0] hi;
		logic                       last;
	} group_res_t;

	typedef struct {
		row_kind_t                  kind;
		logic                       reg_sel;
		logic [APB_DW-1:0]          value;
		logic [CHAN_W-1:0]          chan;
		logic signed [SAMPLE_W-1:0] smp;
		int                         n_typed;  // -1: use the predictor
		logic [LEVEL_W-1:0]         t_level;
		logic signed [SAMPLE_W-1:0] t_lo;
		logic signed [SAMPLE_W-1:0] t_hi;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	mmd_in_if  samples_if ();
	mmd_out_if results_if ();

	multiscale_min_max_decimator_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.samples (samples_if),
		.results (results_if)
	);

	// predictor state: one entry per (channel, level)
	logic [COUNT_W-1:0]         grp_fill [MAX_CH*MAX_LV];
	logic signed [SAMPLE_W-1:0] grp_lo   [MAX_CH*MAX_LV];
	logic signed [SAMPLE_W-1:0] grp_hi   [MAX_CH*MAX_LV];
	logic [NCH_W-1:0]           cfg_channels;
	logic [NLV_W-1:0]           cfg_levels;

	group_res_t pending_groups[$];
	dir_row_t   dir_rows[$];

	int errors;
	int n_sent;
	int n_dropped;
	int n_results;
	int n_writes;
	int deepest;
	int send_idle_pct;
	int recv_idle_pct;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		#2_000_000;
		$display("timeout: %0d results still pending", pending_groups.size());
		$display("** multiscale_min_max_decimator_top: FAILED **");
		$finish;
	end

	task automatic report(input string what, input int got, input int want);
		errors++;
		$display("%0t ns: %s mismatch, got %0d, want %0d", $time, what, got, want);
	endtask

	// Folds one sample into its channel's pyramid; returns completed groups.
	function automatic void fold_sample(input logic [CHAN_W-1:0] ch,
		input logic signed [SAMPLE_W-1:0] s, output group_res_t res[$]);
		int lvls;
		int idx;
		logic signed [SAMPLE_W-1:0] lo;
		logic signed [SAMPLE_W-1:0] hi;
		group_res_t r;
		res = {};
		if (NCH_W'(ch) >= cfg_channels)
			return;
		lvls = (int'(cfg_levels) > MAX_LV) ? MAX_LV : int'(cfg_levels);
		lo = s;
		hi = s;
		for (int lv = 0; lv < lvls; lv++) begin
			idx = int'(ch) * MAX_LV + lv;
			if (grp_fill[idx] == CNT_EMPTY) begin
				grp_lo[idx] = lo;
				grp_hi[idx] = hi;
				grp_fill[idx] = CNT_ONE;
				break;
			end
			if (lo < grp_lo[idx])
				grp_lo[idx] = lo;
			if (hi > grp_hi[idx])
				grp_hi[idx] = hi;
			if (grp_fill[idx] == CNT_ONE) begin
				grp_fill[idx] = CNT_TWO;
				break;
			end
			grp_fill[idx] = CNT_EMPTY;
			lo = grp_lo[idx];
			hi = grp_hi[idx];
			r.level = LEVEL_W'(lv + 1);
			r.chan = ch;
			r.lo = lo;
			r.hi = hi;
			r.last = 1'b0;
			res.push_back(r);
		end
		if (res.size() > 0)
			res[res.size()-1].last = 1'b1;
	endfunction

	// Entered and left at a falling edge.
	task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic signed [SAMPLE_W-1:0] s,
		input int n_typed, input logic [LEVEL_W-1:0] t_level,
		input logic signed [SAMPLE_W-1:0] t_lo, input logic signed [SAMPLE_W-1:0] t_hi);
		group_res_t fresh[$];
		group_res_t r;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			samples_if.valid = 1'b0;
			@(negedge clk);
		end
		samples_if.valid = 1'b1;
		samples_if.channel = ch;
		samples_if.sample = s;
		do @(posedge clk); while (!samples_if.ready);
		n_sent++;
		if (NCH_W'(ch) >= cfg_channels || cfg_levels == '0)
			n_dropped++;
		fold_sample(ch, s, fresh);
		if (n_typed < 0) begin
			foreach (fresh[i])
				pending_groups.push_back(fresh[i]);
		end else if (n_typed > 0) begin
			r.level = t_level;
			r.chan = ch;
			r.lo = t_lo;
			r.hi = t_hi;
			r.last = 1'b1;
			pending_groups.push_back(r);
		end
		@(negedge clk);
	endtask

	// Idle point before a register write: all results out, walk finished.
	task automatic flush_wait();
		samples_if.valid = 1'b0;
		while (pending_groups.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic reg_sel, input logic [APB_DW-1:0] value);
		logic [APB_DW-1:0] rd;
		logic [APB_DW-1:0] mask;
		paddr = APB_AW'({reg_sel, 2'b00});
		pwdata = value;
		pwrite = 1'b1;
		psel = 1'b1;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		n_writes++;
		if (reg_sel == REG_NUM_CHANNELS)
			cfg_channels = value[NCH_W-1:0];
		else
			cfg_levels = value[NLV_W-1:0];
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		mask = (reg_sel == REG_NUM_CHANNELS) ? APB_DW'((1 << NCH_W) - 1) : APB_DW'((1 << NLV_W) - 1);
		if ((rd & mask) != (value & mask))
			report("register readback", int'(rd & mask), int'(value & mask));
	endtask

	task automatic dir_wr(input logic reg_sel, input logic [APB_DW-1:0] value);
		dir_row_t row;
		row = '{kind: ROW_WRITE, reg_sel: reg_sel, value: value, chan: '0, smp: '0,
			n_typed: 0, t_level: '0, t_lo: '0, t_hi: '0};
		dir_rows.push_back(row);
	endtask

	task automatic dir_smp(input logic [CHAN_W-1:0] ch, input logic signed [SAMPLE_W-1:0] s,
		input int n_typed, input logic [LEVEL_W-1:0] t_level = '0,
		input logic signed [SAMPLE_W-1:0] t_lo = '0, input logic signed [SAMPLE_W-1:0] t_hi = '0);
		dir_row_t row;
		row = '{kind: ROW_SAMPLE, reg_sel: 1'b0, value: '0, chan: ch, smp: s,
			n_typed: n_typed, t_level: t_level, t_lo: t_lo, t_hi: t_hi};
		dir_rows.push_back(row);
	endtask

	always @(negedge clk)
		results_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

	always @(posedge clk) begin
		group_res_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			n_results++;
			if (int'(results_if.level) > deepest)
				deepest = int'(results_if.level);
			if (pending_groups.size() == 0) begin
				report("result with nothing pending, level", int'(results_if.level), 0);
			end else begin
				want = pending_groups.pop_front();
				if (results_if.level !== want.level)
					report("level", int'(results_if.level), int'(want.level));
				if (results_if.out_channel !== want.chan)
					report("out_channel", int'(results_if.out_channel), int'(want.chan));
				if (results_if.min_value !== want.lo)
					report("min_value", int'(results_if.min_value), int'(want.lo));
				if (results_if.max_value !== want.hi)
					report("max_value", int'(results_if.max_value), int'(want.hi));
				if (results_if.last !== want.last)
					report("last", int'(results_if.last), int'(want.last));
			end
		end
	end

	initial begin
		int useful;
		int seg_len;
		int pick;
		logic [NCH_W-1:0] nch;
		logic [NLV_W-1:0] nlv;
		logic [CHAN_W-1:0] ch;
		logic signed [SAMPLE_W-1:0] s;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		samples_if.valid = 1'b0;
		samples_if.channel = '0;
		samples_if.sample = '0;
		results_if.ready = 1'b0;
		errors = 0;
		n_sent = 0;
		n_dropped = 0;
		n_results = 0;
		n_writes = 0;
		deepest = 0;
		send_idle_pct = 33;
		recv_idle_pct = 74;
		cfg_channels = NUM_CHANNELS_RST;
		cfg_levels = NUM_LEVELS_RST;
		foreach (grp_fill[i]) begin
			grp_fill[i] = CNT_EMPTY;
			grp_lo[i] = '0;
			grp_hi[i] = '0;
		end

		// out of reset: one channel, all twelve levels
		dir_smp(6'd0, -16'sd32768, 0);
		dir_smp(6'd0, 16'sd32767, 0);
		dir_smp(6'd0, 16'sd0, 1, 4'd1, -16'sd32768, 16'sd32767);
		dir_smp(6'd1, 16'sd5, 0);                // channel not in use
		dir_smp(6'd63, -16'sd1, 0);
		dir_wr(REG_NUM_CHANNELS, 32'd64);
		dir_smp(6'd63, 16'sd32767, 0);
		dir_smp(6'd63, -16'sd32768, 0);
		dir_smp(6'd63, 16'sd1, 1, 4'd1, -16'sd32768, 16'sd32767);
		dir_smp(6'd42, 16'sh5555, -1);
		dir_smp(6'd21, 16'shAAAA, -1);
		dir_wr(REG_NUM_LEVELS, 32'd0);           // no levels: nothing moves
		dir_smp(6'd0, 16'sd100, 0);
		dir_smp(6'd0, -16'sd100, 0);
		dir_wr(REG_NUM_LEVELS, 32'd15);          // above the maximum, clipped
		dir_smp(6'd0, 16'sd7, -1);
		dir_smp(6'd0, 16'sd8, -1);
		dir_smp(6'd0, 16'sd9, -1);
		dir_smp(6'd0, 16'sd1, -1);
		dir_smp(6'd0, 16'sd2, -1);
		dir_smp(6'd0, 16'sd3, -1);               // closes levels 1 and 2
		dir_wr(REG_NUM_LEVELS, 32'd1);
		dir_smp(6'd0, 16'sd4, 0);
		dir_smp(6'd0, 16'sd5, 0);
		dir_smp(6'd0, 16'sd6, 1, 4'd1, 16'sd4, 16'sd6);
		dir_wr(REG_NUM_CHANNELS, 32'd0);
		dir_smp(6'd0, -16'sd7, 0);
		dir_wr(REG_NUM_CHANNELS, 32'd127);
		dir_wr(REG_NUM_LEVELS, 32'd12);
		dir_smp(6'd63, 16'sd0, -1);              // opens a new group on channel 63
		dir_smp(6'd0, -16'sd32768, -1);

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_WRITE) begin
				flush_wait();
				write_reg(dir_rows[i].reg_sel, dir_rows[i].value);
			end else begin
				send_sample(dir_rows[i].chan, dir_rows[i].smp, dir_rows[i].n_typed,
					dir_rows[i].t_level, dir_rows[i].t_lo, dir_rows[i].t_hi);
			end
		end

		// random segments, each at its own setting, idle between them
		useful = 0;
		while (useful < RAND_ITEMS) begin
			if (useful < RAND_ITEMS / 3) begin
				send_idle_pct = 33;
				recv_idle_pct = 74;
			end else if (useful < 2 * RAND_ITEMS / 3) begin
				send_idle_pct = 74;
				recv_idle_pct = 33;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			pick = $urandom_range(0, 9);
			case (pick)
				0, 1: nch = 7'd1;
				2: nch = 7'd2;
				3: nch = 7'd3;
				4: nch = 7'd64;
				5: nch = 7'd127;
				6: nch = 7'd0;
				default: nch = NCH_W'($urandom_range(4, 16));
			endcase
			pick = $urandom_range(0, 9);
			case (pick)
				0: nlv = 4'd0;
				1: nlv = 4'd15;
				2: nlv = 4'd1;
				3: nlv = 4'd13;
				default: nlv = NLV_W'($urandom_range(2, 12));
			endcase
			flush_wait();
			write_reg(REG_NUM_CHANNELS, APB_DW'(nch));
			write_reg(REG_NUM_LEVELS, APB_DW'(nlv));
			seg_len = (nch == 0 || nlv == 0) ? 3 : $urandom_range(12, 40);
			for (int k = 0; k < seg_len; k++) begin
				if (nch != 0 && $urandom_range(0, 99) < 85)
					ch = CHAN_W'($urandom_range(0, ((nch > 64) ? 64 : int'(nch)) - 1));
				else
					ch = CHAN_W'($urandom_range(0, 63));
				pick = $urandom_range(0, 19);
				case (pick)
					0: s = -16'sd32768;
					1: s = 16'sd32767;
					2: s = 16'sd0;
					default: s = SAMPLE_W'($urandom_range(0, 65535));
				endcase
				if (NCH_W'(ch) < nch && nlv != 0)
					useful++;
				send_sample(ch, s, -1, '0, '0, '0);
			end
		end

		samples_if.valid = 1'b0;
		while (pending_groups.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d samples (%0d dropped by the settings), %0d results checked",
			n_sent, n_dropped, n_results);
		$display("deepest level seen %0d, %0d register writes", deepest, n_writes);
		if (errors == 0)
			$display("** multiscale_min_max_decimator_top: PASSED **");
		else
			$display("** multiscale_min_max_decimator_top: FAILED **");
		$finish;
	end

endmodule

// File: filelist.f
src/mmd_pkg.sv
src/mmd_if.sv
src/mmd_regs.sv
src/mmd_ctrl.sv
src/mmd_dp.sv
src/multiscale_min_max_decimator_top.sv
sim/multiscale_min_max_decimator_top_tb.sv
